/* hw/rtl/move_to_target_speed_profile_macros.svh */
// Assertion macros for the move-to-target speed profile checker
`ifndef MOVE_TO_TARGET_SPEED_PROFILE_MACROS_SVH
`define MOVE_TO_TARGET_SPEED_PROFILE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MTSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mtsp_pkg.sv */
// Shared constants, codes and controller/datapath types for the speed profile block
package mtsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SNAP_T = ((2 << FRAC_BITS) + 500) / 1000;
  localparam logic [63:0] SNAP_SQ = 64'(SNAP_T * SNAP_T);
  localparam logic [30:0] MAX_SPEED_RST = 31'd65536;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
  localparam logic [2:0] CFG_ACCEL = 3'd1;
  localparam logic [2:0] CFG_DECEL = 3'd2;
  localparam logic [2:0] CFG_TARGET_X = 3'd3;
  localparam logic [2:0] CFG_TARGET_Y = 3'd4;
  localparam logic [2:0] CFG_TARGET_Z = 3'd5;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  typedef enum logic [3:0] {
    MUL_DX, MUL_DY, MUL_DZ, MUL_MSMS, MUL_MSL, MUL_DTACC, MUL_SPDT,
    MUL_RX, MUL_RY, MUL_RZ
  } mul_sel_t;

  typedef enum logic [1:0] {DIV_DD, DIV_ALW, DIV_R} div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_ACC, ST_SNAP, ST_SQRT,
    ST_SPEED, ST_DD_INIT, ST_DD_DIV, ST_DD_LD, ST_ALW_CHK, ST_ALW_INIT, ST_ALW_DIV,
    ST_ALW_LD, ST_WANT_MUL, ST_WANT, ST_TRAV_MUL, ST_TRAV, ST_R_INIT, ST_R_DIV,
    ST_R_LD, ST_MOV_X, ST_MOV_Y, ST_MOV_Z, ST_MOV_END, ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     set_run;
    logic     clr_run;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     snap_out;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    div_sel_t div_sel;
    logic     div_step;
    logic     ld_dd;
    logic     set_alw_max;
    logic     ld_alw;
    logic     ld_speed;
    logic     ld_travel;
    logic     ld_r;
    logic     ld_nx;
    logic     ld_ny;
    logic     ld_nz;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       run;
    logic       snap;
    logic       dec_zero;
    logic       dd_ok;
    logic       out_free;
  } sts_t;

  // Move one axis toward the target by |d| * r / 2^32, split as high and low parts
  function automatic logic [31:0] step_axis(input logic [31:0] p, input logic d_neg,
                                            input logic [32:0] m, input logic [63:0] plo,
                                            input logic [32:0] r);
    logic [33:0] s;
    logic [33:0] pe;
    s = (m[32] ? {1'b0, r} : 34'd0) + {2'b00, plo[63:32]};
    pe = {{2{p[31]}}, p};
    step_axis = d_neg ? 32'(pe - s) : 32'(pe + s);
  endfunction

endpackage

/* hw/rtl/mtsp_ctrl.sv */
// Sequencer state machine for the speed profile block
module mtsp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  mtsp_pkg::sts_t sts,
  output mtsp_pkg::cmd_t cmd
);

  mtsp_pkg::state_t state, state_next;
  logic [mtsp_pkg::CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtsp_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.mul_sel = mtsp_pkg::MUL_DX;
    cmd.div_sel = mtsp_pkg::DIV_DD;
    s_axis_tready = 1'b0;
    case (state)
      mtsp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next = mtsp_pkg::ST_DECODE;
        end
      end
      mtsp_pkg::ST_DECODE: begin
        state_next = mtsp_pkg::ST_DONE;
        if (sts.func == mtsp_pkg::FUNC_START) cmd.set_run = 1'b1;
        else if (sts.func == mtsp_pkg::FUNC_STOP) cmd.clr_run = 1'b1;
        else if (sts.func == mtsp_pkg::FUNC_TICK && sts.run) state_next = mtsp_pkg::ST_SQ_X;
      end
      mtsp_pkg::ST_SQ_X: begin
        cmd.mul_sel = mtsp_pkg::MUL_DX;
        cmd.acc_clr = 1'b1;
        state_next = mtsp_pkg::ST_SQ_Y;
      end
      mtsp_pkg::ST_SQ_Y: begin
        cmd.mul_sel = mtsp_pkg::MUL_DY;
        cmd.acc_add = 1'b1;
        state_next = mtsp_pkg::ST_SQ_Z;
      end
      mtsp_pkg::ST_SQ_Z: begin
        cmd.mul_sel = mtsp_pkg::MUL_DZ;
        cmd.acc_add = 1'b1;
        state_next = mtsp_pkg::ST_SQ_ACC;
      end
      mtsp_pkg::ST_SQ_ACC: begin
        cmd.acc_add = 1'b1;
        state_next = mtsp_pkg::ST_SNAP;
      end
      mtsp_pkg::ST_SNAP: begin
        if (sts.snap) begin
          cmd.snap_out = 1'b1;
          state_next = mtsp_pkg::ST_DONE;
        end else begin
          cmd.sqrt_init = 1'b1;
          cnt_next = '0;
          state_next = mtsp_pkg::ST_SQRT;
        end
      end
      mtsp_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == mtsp_pkg::CNT_W'(mtsp_pkg::SQRT_STEPS - 1)) state_next = mtsp_pkg::ST_SPEED;
      end
      mtsp_pkg::ST_SPEED: begin
        cmd.set_alw_max = 1'b1;
        cmd.mul_sel = mtsp_pkg::MUL_MSMS;
        state_next = sts.dec_zero ? mtsp_pkg::ST_WANT_MUL : mtsp_pkg::ST_DD_INIT;
      end
      mtsp_pkg::ST_DD_INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel = mtsp_pkg::DIV_DD;
        cnt_next = '0;
        state_next = mtsp_pkg::ST_DD_DIV;
      end
      mtsp_pkg::ST_DD_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == mtsp_pkg::CNT_W'(mtsp_pkg::DIV_STEPS - 1)) state_next = mtsp_pkg::ST_DD_LD;
      end
      mtsp_pkg::ST_DD_LD: begin
        cmd.ld_dd = 1'b1;
        state_next = mtsp_pkg::ST_ALW_CHK;
      end
      mtsp_pkg::ST_ALW_CHK: begin
        cmd.mul_sel = mtsp_pkg::MUL_MSL;
        state_next = sts.dd_ok ? mtsp_pkg::ST_ALW_INIT : mtsp_pkg::ST_WANT_MUL;
      end
      mtsp_pkg::ST_ALW_INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel = mtsp_pkg::DIV_ALW;
        cnt_next = '0;
        state_next = mtsp_pkg::ST_ALW_DIV;
      end
      mtsp_pkg::ST_ALW_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == mtsp_pkg::CNT_W'(mtsp_pkg::DIV_STEPS - 1)) state_next = mtsp_pkg::ST_ALW_LD;
      end
      mtsp_pkg::ST_ALW_LD: begin
        cmd.ld_alw = 1'b1;
        state_next = mtsp_pkg::ST_WANT_MUL;
      end
      mtsp_pkg::ST_WANT_MUL: begin
        cmd.mul_sel = mtsp_pkg::MUL_DTACC;
        state_next = mtsp_pkg::ST_WANT;
      end
      mtsp_pkg::ST_WANT: begin
        cmd.ld_speed = 1'b1;
        state_next = mtsp_pkg::ST_TRAV_MUL;
      end
      mtsp_pkg::ST_TRAV_MUL: begin
        cmd.mul_sel = mtsp_pkg::MUL_SPDT;
        state_next = mtsp_pkg::ST_TRAV;
      end
      mtsp_pkg::ST_TRAV: begin
        cmd.ld_travel = 1'b1;
        state_next = mtsp_pkg::ST_R_INIT;
      end
      mtsp_pkg::ST_R_INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel = mtsp_pkg::DIV_R;
        cnt_next = '0;
        state_next = mtsp_pkg::ST_R_DIV;
      end
      mtsp_pkg::ST_R_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == mtsp_pkg::CNT_W'(mtsp_pkg::DIV_STEPS - 1)) state_next = mtsp_pkg::ST_R_LD;
      end
      mtsp_pkg::ST_R_LD: begin
        cmd.ld_r = 1'b1;
        state_next = mtsp_pkg::ST_MOV_X;
      end
      mtsp_pkg::ST_MOV_X: begin
        cmd.mul_sel = mtsp_pkg::MUL_RX;
        state_next = mtsp_pkg::ST_MOV_Y;
      end
      mtsp_pkg::ST_MOV_Y: begin
        cmd.mul_sel = mtsp_pkg::MUL_RY;
        cmd.ld_nx = 1'b1;
        state_next = mtsp_pkg::ST_MOV_Z;
      end
      mtsp_pkg::ST_MOV_Z: begin
        cmd.mul_sel = mtsp_pkg::MUL_RZ;
        cmd.ld_ny = 1'b1;
        state_next = mtsp_pkg::ST_MOV_END;
      end
      mtsp_pkg::ST_MOV_END: begin
        cmd.ld_nz = 1'b1;
        state_next = mtsp_pkg::ST_DONE;
      end
      mtsp_pkg::ST_DONE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = mtsp_pkg::ST_IDLE;
        end
      end
      default: state_next = mtsp_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/mtsp_dp.sv */
// Datapath: config registers, shared multiplier, square root and divider steps, output register
module mtsp_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic [1:0]     in_func,
  input  logic [111:0]   in_data,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [127:0]   m_axis_tdata,
  output logic [1:0]     m_axis_tuser,
  input  mtsp_pkg::cmd_t cmd,
  output mtsp_pkg::sts_t sts
);

  logic [30:0] max_speed, accel, decel;
  logic [31:0] target_x, target_y, target_z;
  logic        run_flag;
  logic [30:0] cur_speed;

  logic [1:0]  func;
  logic [31:0] px, py, pz;
  logic [15:0] dt;

  logic [32:0] dx, dy, dz, mx, my, mz;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [64:0] acc_sum;
  logic [63:0] acc_s;

  logic [63:0] rad;
  logic [33:0] srem;
  logic [31:0] root;
  logic [35:0] srem_sh, strial;

  logic [63:0] dnum, dden, drem, quo;
  logic [64:0] drem_sh;

  logic [63:0] dd;
  logic [30:0] allowed;
  logic [31:0] want;
  logic [31:0] travel;
  logic [32:0] r;

  logic [31:0] nx, ny, nz;
  logic        reached;
  logic        out_valid;

  // distances and magnitudes, 33-bit signed
  assign dx = {target_x[31], target_x} - {px[31], px};
  assign dy = {target_y[31], target_y} - {py[31], py};
  assign dz = {target_z[31], target_z} - {pz[31], pz};
  assign mx = dx[32] ? 33'(-dx) : dx;
  assign my = dy[32] ? 33'(-dy) : dy;
  assign mz = dz[32] ? 33'(-dz) : dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= mtsp_pkg::MAX_SPEED_RST;
      accel <= '0;
      decel <= '0;
      target_x <= '0;
      target_y <= '0;
      target_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mtsp_pkg::CFG_MAX_SPEED: max_speed <= cfg_data[30:0];
        mtsp_pkg::CFG_ACCEL:     accel <= cfg_data[30:0];
        mtsp_pkg::CFG_DECEL:     decel <= cfg_data[30:0];
        mtsp_pkg::CFG_TARGET_X:  target_x <= cfg_data;
        mtsp_pkg::CFG_TARGET_Y:  target_y <= cfg_data;
        mtsp_pkg::CFG_TARGET_Z:  target_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      mtsp_pkg::MUL_DX:    begin mul_a = mx; mul_b = mx; end
      mtsp_pkg::MUL_DY:    begin mul_a = my; mul_b = my; end
      mtsp_pkg::MUL_DZ:    begin mul_a = mz; mul_b = mz; end
      mtsp_pkg::MUL_MSMS:  begin mul_a = {2'b00, max_speed}; mul_b = {2'b00, max_speed}; end
      mtsp_pkg::MUL_MSL:   begin mul_a = {2'b00, max_speed}; mul_b = {1'b0, root}; end
      mtsp_pkg::MUL_DTACC: begin mul_a = {17'd0, dt}; mul_b = {2'b00, accel}; end
      mtsp_pkg::MUL_SPDT:  begin mul_a = {2'b00, cur_speed}; mul_b = {17'd0, dt}; end
      mtsp_pkg::MUL_RX:    begin mul_a = {1'b0, mx[31:0]}; mul_b = r; end
      mtsp_pkg::MUL_RY:    begin mul_a = {1'b0, my[31:0]}; mul_b = r; end
      mtsp_pkg::MUL_RZ:    begin mul_a = {1'b0, mz[31:0]}; mul_b = r; end
      default: ;
    endcase
  end

  assign acc_sum = {1'b0, acc_s} + {1'b0, prod[63:0]};
  assign srem_sh = {srem, rad[63:62]};
  assign strial = {2'b00, root, 2'b01};
  assign drem_sh = {drem, dnum[63]};

  always_comb begin
    if (accel == '0) want = {1'b0, max_speed};
    else want = {1'b0, cur_speed} + {1'b0, prod[46:16]};
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (cmd.load_in) begin
      func <= in_func;
      px <= in_data[31:0];
      py <= in_data[63:32];
      pz <= in_data[95:64];
      dt <= in_data[111:96];
      nx <= in_data[31:0];
      ny <= in_data[63:32];
      nz <= in_data[95:64];
      reached <= 1'b0;
    end

    if (cmd.acc_clr) acc_s <= '0;
    else if (cmd.acc_add) begin
      // saturate on a square past 64 bits or on carry out
      if (acc_sum[64] || (prod[65:64] != 2'b00)) acc_s <= '1;
      else acc_s <= acc_sum[63:0];
    end

    if (cmd.snap_out) begin
      nx <= target_x;
      ny <= target_y;
      nz <= target_z;
      reached <= 1'b1;
    end

    if (cmd.sqrt_init) begin
      rad <= acc_s;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[61:0], 2'b00};
      if (srem_sh >= strial) begin
        srem <= 34'(srem_sh - strial);
        root <= {root[30:0], 1'b1};
      end else begin
        srem <= srem_sh[33:0];
        root <= {root[30:0], 1'b0};
      end
    end

    if (cmd.div_init) begin
      drem <= '0;
      quo <= '0;
      case (cmd.div_sel)
        mtsp_pkg::DIV_DD:  begin dnum <= prod[63:0]; dden <= {33'd0, decel}; end
        mtsp_pkg::DIV_ALW: begin dnum <= prod[63:0]; dden <= dd; end
        mtsp_pkg::DIV_R:   begin dnum <= {travel, 32'd0}; dden <= {32'd0, root}; end
        default:           begin dnum <= prod[63:0]; dden <= dd; end
      endcase
    end else if (cmd.div_step) begin
      dnum <= {dnum[62:0], 1'b0};
      if (drem_sh >= {1'b0, dden}) begin
        drem <= 64'(drem_sh - {1'b0, dden});
        quo <= {quo[62:0], 1'b1};
      end else begin
        drem <= drem_sh[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end

    if (cmd.ld_dd) dd <= quo;
    if (cmd.set_alw_max) allowed <= max_speed;
    else if (cmd.ld_alw) allowed <= quo[30:0];

    if (cmd.ld_travel) begin
      if ({1'b0, prod[46:16]} > root) travel <= root;
      else travel <= {1'b0, prod[46:16]};
    end
    if (cmd.ld_r) r <= quo[32:0];

    if (cmd.ld_nx) nx <= mtsp_pkg::step_axis(px, dx[32], mx, prod[63:0], r);
    if (cmd.ld_ny) ny <= mtsp_pkg::step_axis(py, dy[32], my, prod[63:0], r);
    if (cmd.ld_nz) nz <= mtsp_pkg::step_axis(pz, dz[32], mz, prod[63:0], r);

    if (cmd.out_load) begin
      m_axis_tdata <= {1'b0, cur_speed, nz, ny, nx};
      m_axis_tuser <= {run_flag, reached};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      cur_speed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_run) run_flag <= 1'b1;
      else if (cmd.clr_run || cmd.snap_out) run_flag <= 1'b0;
      if (cmd.ld_speed) begin
        if (want > {1'b0, allowed}) cur_speed <= allowed;
        else cur_speed <= want[30:0];
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;

  assign sts.func = func;
  assign sts.run = run_flag;
  assign sts.snap = (acc_s <= mtsp_pkg::SNAP_SQ);
  assign sts.dec_zero = (decel == '0);
  assign sts.dd_ok = (dd != '0) && ({32'd0, root} <= dd);
  assign sts.out_free = !out_valid || m_axis_tready;

endmodule

/* hw/rtl/move_to_target_speed_profile.sv */
// Top level of the move-to-target speed profile block
//
//  channel   | direction | handshake          | payload
//  s_axis    | in        | tvalid/tready      | tdata: pos_x, pos_y, pos_z, time_step; tuser: func
//  m_axis    | out       | tvalid/tready      | tdata: new_x, new_y, new_z, speed; tuser: flags
//  cfg       | in        | cfg_we             | cfg_index, cfg_data
//
// One item at a time. Start, stop, idle and unused-code items skip the arithmetic; a snap
// stops after the squared distance. A moving tick runs without deceleration, or with it
// outside or inside the slow-down zone: a 32-step square root and up to three 64-step
// restoring divisions share one datapath, plus one 33x33 multiplier.
// Reset (rst, synchronous) clears the run flag and the speed and restores config defaults.
// A finished result waits in the output register; the next item is taken meanwhile
// and stalls only at its end if the result is still not taken.
module move_to_target_speed_profile (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // pos_x, pos_y, pos_z, time_step
  input  logic [1:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // new_x, new_y, new_z, speed, zero pad
  output logic [1:0]   m_axis_tuser,   // reached_end, running
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  mtsp_pkg::cmd_t cmd;
  mtsp_pkg::sts_t sts;

  mtsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mtsp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_func      (s_axis_tuser),
    .in_data      (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* hw/rtl/mtsp_checker.sv */
// Port-level checker for the speed profile block, bound to the top level
`include "move_to_target_speed_profile_macros.svh"

module mtsp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  `MTSP_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `MTSP_ASSERT_NXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `MTSP_ASSERT_IMP(a_reach_stops, clk, rst, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1], "arrival reported while still running")
  `MTSP_ASSERT_NXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

bind move_to_target_speed_profile mtsp_checker u_mtsp_checker (.*);
